>>> hw/rtl/tvdr_pkg.sv
// Shared types, codes and defaults of the tile viewport renderer.
package tvdr_pkg;

	localparam int MAP_COLS_DEF  = 32;
	localparam int MAP_ROWS_DEF  = 32;
	localparam int VIEW_COLS_DEF = 16;
	localparam int VIEW_ROWS_DEF = 2;

	// coordinate working width: covers map extents plus a window span
	localparam int CW     = 7;
	// width for address products before they are cut to size
	localparam int WIDE_W = 13;

	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_RENDER = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [1:0] SELF_P2 = 2'd2;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_PLAYER  = 8'h07;
	localparam logic [7:0] SHADOW_BLANK = 8'hff;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_SELF,
		ST_OTHER,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [3:0] col;
		logic       row;
		logic [7:0] ch;
	} wr_t;

endpackage

>>> hw/rtl/tvdr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tvdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/tile_viewport_diff_renderer_core.sv
// Top level of the tile viewport renderer: request decode, window walk and write queue.
//
// Usage
//   Requests arrive on the in channel (in_valid / in_stall) and carry a type:
//   write tile stores cell_value at (cell_x, cell_y) of the tile map; clear
//   marks every shadow cell as 0xff so the next render redraws the window;
//   render centres the window on the own player, clamps it at the map edges
//   and emits one character write per window cell that differs from the
//   shadow, then a player glyph for the own and the other player if inside.
//   Character writes leave on the out channel (out_valid / out_stall); the
//   final write of a render carries last_write. A render with nothing to
//   draw sends nothing.
// Timing
//   A render walks the window cells, one a cycle while the receiver does not
//   stall, through the tile and shadow RAM read ports, then the drain, two
//   glyphs and flush. The registered RAM read sets the pace; in_stall is high
//   for the whole render.
// Reset and stalls
//   Reset empties the shadow (all cells read as 0xff) and sets the empty code
//   to 0; the tile map is undefined until written. While the receiver stalls,
//   the walk holds and re-reads the current cell; no write is lost.
module tile_viewport_diff_renderer_core #(
	parameter int MAP_COLS  = tvdr_pkg::MAP_COLS_DEF,
	parameter int MAP_ROWS  = tvdr_pkg::MAP_ROWS_DEF,
	parameter int VIEW_COLS = tvdr_pkg::VIEW_COLS_DEF,
	parameter int VIEW_ROWS = tvdr_pkg::VIEW_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [4:0] cell_x,
	input  logic [4:0] cell_y,
	input  logic [7:0] cell_value,
	input  logic [1:0] self_id,
	input  logic [4:0] p1_x,
	input  logic [4:0] p1_y,
	input  logic [4:0] p2_x,
	input  logic [4:0] p2_y,
	// character write channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] out_col,
	output logic       out_row,
	output logic [7:0] out_char,
	output logic       last_write
);

	import tvdr_pkg::*;

	localparam int MAP_N  = MAP_COLS * MAP_ROWS;
	localparam int AW     = $clog2(MAP_N);
	localparam int SH_N   = VIEW_COLS * VIEW_ROWS;
	localparam int SW     = $clog2(SH_N);
	// visible span of the window: never more than the map itself
	localparam int SPAN_C = (VIEW_COLS < MAP_COLS) ? VIEW_COLS : MAP_COLS;
	localparam int SPAN_R = (VIEW_ROWS < MAP_ROWS) ? VIEW_ROWS : MAP_ROWS;
	localparam int VCW    = $clog2(SPAN_C);
	localparam int RW     = (SPAN_R > 1) ? $clog2(SPAN_R) : 1;
	localparam int HALF_C = VIEW_COLS / 2;
	localparam int HALF_R = VIEW_ROWS / 2;
	localparam int TOP_C  = (MAP_COLS > VIEW_COLS) ? MAP_COLS - VIEW_COLS : 0;
	localparam int TOP_R  = (MAP_ROWS > VIEW_ROWS) ? MAP_ROWS - VIEW_ROWS : 0;

	// Window start on one axis: pinned to 0 near the low edge, to the last
	// full position near the high edge, centred on the player elsewhere.
	function automatic logic [CW-1:0] win_start(input logic [CW-1:0] pos,
			input logic [CW-1:0] half, input logic [CW-1:0] size,
			input logic [CW-1:0] top);
		logic [CW-1:0] s;
		if (pos < half) begin
			s = '0;
		end else if (pos + half >= size) begin
			s = top;
		end else begin
			s = pos - half;
		end
		return s;
	endfunction

	// ---------------------------------------------------------------------
	// registers
	// ---------------------------------------------------------------------
	state_t           state_q, state_d;
	logic [7:0]       empty_q;
	logic [SH_N-1:0]  sh_valid_q;
	logic [CW-1:0]    sx_q, sy_q;
	logic [4:0]       ux_q, uy_q, ox_q, oy_q;
	logic [VCW-1:0]   ic_q;
	logic [RW-1:0]    ir_q;
	logic             valid_s1;
	logic [VCW-1:0]   c_s1;
	logic [RW-1:0]    r_s1;
	logic [AW-1:0]    taddr_s1;
	logic [SW-1:0]    si_s1;
	logic             hold_valid_q;
	wr_t              hold_q;
	logic             out_valid_q;
	wr_t              out_q;
	logic             out_last_q;

	// ---------------------------------------------------------------------
	// combinational signals
	// ---------------------------------------------------------------------
	logic             in_acc;
	logic             adv;
	logic             walk_last;
	logic [CW-1:0]    iss_x, iss_y;
	logic [WIDE_W-1:0] iss_addr_w, iss_si_w, wr_addr_w, pl_si_w;
	logic [AW-1:0]    iss_addr;
	logic [SW-1:0]    iss_si;
	logic             wr_in_map;
	logic             t_we;
	logic [AW-1:0]    t_waddr, t_raddr;
	logic [7:0]       t_rdata;
	logic             sh_we;
	logic [SW-1:0]    sh_waddr, sh_raddr;
	logic [7:0]       sh_wdata, sh_rdata;
	logic [7:0]       shadow_eff;
	logic             cell_diff;
	logic [CW-1:0]    pl_x, pl_y, pl_c, pl_r;
	logic             pl_in;
	logic             gen_valid;
	wr_t              gen;
	logic             push;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	// advance only when the output register can take a write this cycle
	assign adv      = !out_valid_q || !out_stall;

	// next cell to issue into the RAM read ports
	assign iss_x      = sx_q + CW'(ic_q);
	assign iss_y      = sy_q + CW'(ir_q);
	assign iss_addr_w = WIDE_W'(iss_y) * WIDE_W'(MAP_COLS) + WIDE_W'(iss_x);
	assign iss_addr   = iss_addr_w[AW-1:0];
	assign iss_si_w   = WIDE_W'(ir_q) * WIDE_W'(VIEW_COLS) + WIDE_W'(ic_q);
	assign iss_si     = iss_si_w[SW-1:0];
	assign walk_last  = (ic_q == VCW'(SPAN_C - 1)) && (ir_q == RW'(SPAN_R - 1));

	// tile write request: drop writes that fall off the map
	assign wr_in_map = (CW'(cell_x) < CW'(MAP_COLS)) && (CW'(cell_y) < CW'(MAP_ROWS));
	assign wr_addr_w = WIDE_W'(cell_y) * WIDE_W'(MAP_COLS) + WIDE_W'(cell_x);
	assign t_we      = in_acc && (req_type == REQ_WRITE) && wr_in_map;
	assign t_waddr   = wr_addr_w[AW-1:0];

	// shadow entries never written since the last clear read as blank
	assign shadow_eff = sh_valid_q[si_s1] ? sh_rdata : SHADOW_BLANK;
	assign cell_diff  = valid_s1 && (t_rdata != shadow_eff);

	// player under consideration in the glyph states
	assign pl_x  = (state_q == ST_SELF) ? CW'(ux_q) : CW'(ox_q);
	assign pl_y  = (state_q == ST_SELF) ? CW'(uy_q) : CW'(oy_q);
	assign pl_c  = pl_x - sx_q;
	assign pl_r  = pl_y - sy_q;
	assign pl_in = (pl_x >= sx_q) && (pl_x < sx_q + CW'(SPAN_C)) &&
		(pl_y >= sy_q) && (pl_y < sy_q + CW'(SPAN_R));
	assign pl_si_w = WIDE_W'(pl_r) * WIDE_W'(VIEW_COLS) + WIDE_W'(pl_c);

	// ---------------------------------------------------------------------
	// memories
	// ---------------------------------------------------------------------
	tvdr_ram #(
		.WIDTH (8),
		.DEPTH (MAP_N)
	) u_tile_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (cell_value),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	tvdr_ram #(
		.WIDTH (8),
		.DEPTH (SH_N)
	) u_shadow_ram (
		.clk   (clk),
		.we    (sh_we),
		.waddr (sh_waddr),
		.wdata (sh_wdata),
		.raddr (sh_raddr),
		.rdata (sh_rdata)
	);

	// ---------------------------------------------------------------------
	// next state
	// ---------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (req_type == REQ_RENDER)) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (adv && walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (adv) begin
					state_d = ST_SELF;
				end
			end
			ST_SELF: begin
				if (adv) begin
					state_d = ST_OTHER;
				end
			end
			ST_OTHER: begin
				if (adv) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (adv) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// datapath control: RAM ports and the write generated this cycle
	// ---------------------------------------------------------------------
	always_comb begin
		// by default re-read the cell held in stage 1 so stalls keep its data
		t_raddr   = taddr_s1;
		sh_raddr  = si_s1;
		sh_we     = 1'b0;
		sh_waddr  = si_s1;
		sh_wdata  = t_rdata;
		gen_valid = 1'b0;
		gen.col   = 4'(c_s1);
		gen.row   = r_s1[0];
		gen.ch    = (t_rdata == empty_q) ? CHAR_SPACE : t_rdata;
		unique case (state_q) inside
			ST_WALK, ST_DRAIN: begin
				if (adv && (state_q == ST_WALK)) begin
					t_raddr  = iss_addr;
					sh_raddr = iss_si;
				end
				if (adv && cell_diff) begin
					sh_we     = 1'b1;
					gen_valid = 1'b1;
				end
			end
			ST_SELF, ST_OTHER: begin
				gen.col = 4'(pl_c);
				gen.row = pl_r[0];
				gen.ch  = CHAR_PLAYER;
				if (adv && pl_in) begin
					sh_we     = 1'b1;
					sh_waddr  = pl_si_w[SW-1:0];
					sh_wdata  = CHAR_PLAYER;
					gen_valid = 1'b1;
				end
			end
			ST_IDLE, ST_FLUSH: begin
			end
			default: begin
			end
		endcase
	end

	// the held write moves on when a newer one arrives, or at flush as the last
	assign push = adv && hold_valid_q && (gen_valid || (state_q == ST_FLUSH));

	// ---------------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			empty_q      <= '0;
			sh_valid_q   <= '0;
			valid_s1     <= 1'b0;
			ic_q         <= '0;
			ir_q         <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				empty_q <= cfg_wdata;
			end
			if (in_acc && (req_type == REQ_CLEAR)) begin
				sh_valid_q <= '0;
			end else if (sh_we) begin
				sh_valid_q[sh_waddr] <= 1'b1;
			end
			// walk counters and stage 1 occupancy
			if (in_acc && (req_type == REQ_RENDER)) begin
				ic_q     <= '0;
				ir_q     <= '0;
				valid_s1 <= 1'b0;
			end else if (adv && (state_q == ST_WALK)) begin
				valid_s1 <= 1'b1;
				if (ic_q == VCW'(SPAN_C - 1)) begin
					ic_q <= '0;
					ir_q <= ir_q + RW'(1);
				end else begin
					ic_q <= ic_q + VCW'(1);
				end
			end else if (adv && (state_q == ST_DRAIN)) begin
				valid_s1 <= 1'b0;
			end
			// hold one write back so the last one can be flagged
			if (adv && gen_valid) begin
				hold_valid_q <= 1'b1;
			end else if (adv && (state_q == ST_FLUSH)) begin
				hold_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc && (req_type == REQ_RENDER)) begin
			if (self_id == SELF_P2) begin
				ux_q <= p2_x;
				uy_q <= p2_y;
				ox_q <= p1_x;
				oy_q <= p1_y;
				sx_q <= win_start(CW'(p2_x), CW'(HALF_C), CW'(MAP_COLS), CW'(TOP_C));
				sy_q <= win_start(CW'(p2_y), CW'(HALF_R), CW'(MAP_ROWS), CW'(TOP_R));
			end else begin
				ux_q <= p1_x;
				uy_q <= p1_y;
				ox_q <= p2_x;
				oy_q <= p2_y;
				sx_q <= win_start(CW'(p1_x), CW'(HALF_C), CW'(MAP_COLS), CW'(TOP_C));
				sy_q <= win_start(CW'(p1_y), CW'(HALF_R), CW'(MAP_ROWS), CW'(TOP_R));
			end
		end
		if (adv && (state_q == ST_WALK)) begin
			c_s1     <= ic_q;
			r_s1     <= ir_q;
			taddr_s1 <= iss_addr;
			si_s1    <= iss_si;
		end
		if (adv && gen_valid) begin
			hold_q <= gen;
		end
		if (push) begin
			out_q      <= hold_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_col    = out_q.col;
	assign out_row    = out_q.row;
	assign out_char   = out_q.ch;
	assign last_write = out_last_q;

endmodule

>>> verif/tvdr_char_write_checker.sv
// Checker for the tile viewport renderer: predicts character writes and compares them.
`timescale 1ns / 1ps

module tvdr_char_write_checker
	import tvdr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [4:0] cell_x,
	input  logic [4:0] cell_y,
	input  logic [7:0] cell_value,
	input  logic [1:0] self_id,
	input  logic [4:0] p1_x,
	input  logic [4:0] p1_y,
	input  logic [4:0] p2_x,
	input  logic [4:0] p2_y,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [3:0] out_col,
	input  logic       out_row,
	input  logic [7:0] out_char,
	input  logic       last_write,
	output int         fail_count,
	output int         pending
);

	localparam int MAP_C  = MAP_COLS_DEF;
	localparam int MAP_R  = MAP_ROWS_DEF;
	localparam int VIEW_C = VIEW_COLS_DEF;
	localparam int VIEW_R = VIEW_ROWS_DEF;

	typedef struct packed {
		logic [3:0] col;
		logic       row;
		logic [7:0] ch;
		logic       last;
	} char_write_t;

	logic [7:0]  tile_codes [0:MAP_C*MAP_R-1];
	logic [7:0]  shown [0:VIEW_C*VIEW_R-1];
	logic [7:0]  empty_code;
	char_write_t due_writes [$];
	int          mismatches = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// first map line or column of the window, clamped at the map edges
	function automatic int window_origin(int pos, int view, int size);
		int s;
		if (pos - view / 2 < 0) begin
			s = 0;
		end else if (pos + view / 2 > size - 1) begin
			s = size - view;
		end else begin
			s = pos - view / 2;
		end
		return (s < 0) ? 0 : s;
	endfunction

	task automatic queue_glyph(input int px, input int py, input int sx, input int ex,
			input int sy, input int ey);
		if (px >= sx && px < ex && py >= sy && py < ey) begin
			shown[(py - sy) * VIEW_C + (px - sx)] = CHAR_PLAYER;
			due_writes.push_back('{4'(px - sx), 1'(py - sy), CHAR_PLAYER, 1'b0});
		end
	endtask

	task automatic predict_render(input logic [1:0] sid, input logic [4:0] ax,
			input logic [4:0] ay, input logic [4:0] bx, input logic [4:0] by);
		int          ux, uy, ox, oy, sx, ex, sy, ey, x, y, first;
		logic [7:0]  code;
		char_write_t tail;
		first = due_writes.size();
		if (sid == SELF_P2) begin
			ux = bx; uy = by; ox = ax; oy = ay;
		end else begin
			ux = ax; uy = ay; ox = bx; oy = by;
		end
		sx = window_origin(ux, VIEW_C, MAP_C);
		sy = window_origin(uy, VIEW_R, MAP_R);
		ex = (sx + VIEW_C > MAP_C) ? MAP_C : sx + VIEW_C;
		ey = (sy + VIEW_R > MAP_R) ? MAP_R : sy + VIEW_R;
		for (y = sy; y < ey; y++) begin
			for (x = sx; x < ex; x++) begin
				code = tile_codes[y * MAP_C + x];
				if (code != shown[(y - sy) * VIEW_C + (x - sx)]) begin
					shown[(y - sy) * VIEW_C + (x - sx)] = code;
					due_writes.push_back('{4'(x - sx), 1'(y - sy),
						(code == empty_code) ? CHAR_SPACE : code, 1'b0});
				end
			end
		end
		queue_glyph(ux, uy, sx, ex, sy, ey);
		queue_glyph(ox, oy, sx, ex, sy, ey);
		if (due_writes.size() > first) begin
			tail      = due_writes.pop_back();
			tail.last = 1'b1;
			due_writes.push_back(tail);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		char_write_t head;
		if (!arst_n) begin
			foreach (shown[i]) shown[i] = SHADOW_BLANK;
			empty_code = 8'h00;
			due_writes.delete();
		end else begin
			if (cfg_we) begin
				empty_code = cfg_wdata;
			end
			if (out_valid && !out_stall) begin
				if (due_writes.size() == 0) begin
					$error("unexpected character write: col %0d row %0d char %0h last %0b",
						out_col, out_row, out_char, last_write);
					mismatches++;
				end else begin
					head = due_writes.pop_front();
					check_field("out_col", 8'(head.col), 8'(out_col));
					check_field("out_row", 8'(head.row), 8'(out_row));
					check_field("out_char", head.ch, out_char);
					check_field("last_write", 8'(head.last), 8'(last_write));
				end
			end
			if (in_valid && !in_stall) begin
				case (req_type)
					REQ_WRITE: begin
						tile_codes[int'(cell_y) * MAP_C + int'(cell_x)] = cell_value;
					end
					REQ_CLEAR: begin
						foreach (shown[i]) shown[i] = SHADOW_BLANK;
					end
					REQ_RENDER: begin
						predict_render(self_id, p1_x, p1_y, p2_x, p2_y);
					end
					default: begin
					end
				endcase
			end
		end
		fail_count <= mismatches;
		pending    <= due_writes.size();
	end

endmodule

>>> verif/tb.sv
// Testbench top for the tile viewport renderer: request stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb;
	import tvdr_pkg::*;

	localparam int MAP_COLS    = MAP_COLS_DEF;
	localparam int MAP_ROWS    = MAP_ROWS_DEF;
	localparam int VIEW_COLS   = VIEW_COLS_DEF;
	localparam int VIEW_ROWS   = VIEW_ROWS_DEF;
	// request code the block must ignore
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// a render walks every window cell, then drain, glyphs and flush; leave ample room
	localparam int SETTLE_CYCLES = 64;
	localparam int LIMIT_CYCLES  = 400000;

	typedef struct {
		logic [1:0] kind;
		logic [4:0] cx;
		logic [4:0] cy;
		logic [7:0] val;
		logic [1:0] sid;
		logic [4:0] p1x;
		logic [4:0] p1y;
		logic [4:0] p2x;
		logic [4:0] p2y;
	} tile_req_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cfg_we     = 1'b0;
	logic [7:0] cfg_wdata  = 8'h00;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [1:0] req_type   = REQ_WRITE;
	logic [4:0] cell_x     = 5'd0;
	logic [4:0] cell_y     = 5'd0;
	logic [7:0] cell_value = 8'h00;
	logic [1:0] self_id    = 2'd1;
	logic [4:0] p1_x       = 5'd0;
	logic [4:0] p1_y       = 5'd0;
	logic [4:0] p2_x       = 5'd0;
	logic [4:0] p2_y       = 5'd0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [3:0] out_col;
	logic       out_row;
	logic [7:0] out_char;
	logic       last_write;

	int fail_count;
	int pending;
	int cycle_count = 0;
	// requests taken by the block so far, window fills included
	int sent_items  = 0;

	// percentage of cycles in which the sender holds off and the receiver stalls
	int tx_pct = 0;
	int rx_pct = 0;

	// map cells already written; a render is only sent once its whole window is
	bit         tile_written [0:MAP_COLS*MAP_ROWS-1];
	logic [7:0] empty_now = 8'h00;
	int         cur_x     = 0;
	int         cur_y     = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	tile_viewport_diff_renderer_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_value (cell_value),
		.self_id    (self_id),
		.p1_x       (p1_x),
		.p1_y       (p1_y),
		.p2_x       (p2_x),
		.p2_y       (p2_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_col    (out_col),
		.out_row    (out_row),
		.out_char   (out_char),
		.last_write (last_write)
	);

	tvdr_char_write_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_value (cell_value),
		.self_id    (self_id),
		.p1_x       (p1_x),
		.p1_y       (p1_y),
		.p2_x       (p2_x),
		.p2_y       (p2_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_col    (out_col),
		.out_row    (out_row),
		.out_char   (out_char),
		.last_write (last_write),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver stall: a fresh coin each cycle at the current percentage.
	always @(posedge clk) begin
		out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Request with every field random; callers overwrite what matters.
	function automatic tile_req_t noise_req();
		tile_req_t r;
		r.kind = 2'($urandom);
		r.cx   = 5'($urandom);
		r.cy   = 5'($urandom);
		r.val  = 8'($urandom);
		r.sid  = 2'($urandom);
		r.p1x  = 5'($urandom);
		r.p1y  = 5'($urandom);
		r.p2x  = 5'($urandom);
		r.p2y  = 5'($urandom);
		return r;
	endfunction

	// Tile codes weighted towards the interesting ones: the empty code, the
	// shadow blank, the player glyph, space and zero.
	function automatic logic [7:0] tile_code();
		case ($urandom_range(9))
			0: return empty_now;
			1: return SHADOW_BLANK;
			2: return CHAR_PLAYER;
			3: return CHAR_SPACE;
			4: return 8'h00;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Random coordinate within d of pos, kept on the map.
	function automatic logic [4:0] near(input int pos, input int d, input int size);
		int v;
		v = pos + int'($urandom_range(2 * d)) - d;
		if (v < 0) v = 0;
		if (v > size - 1) v = size - 1;
		return 5'(v);
	endfunction

	// First map line or column that a window centred on pos covers.
	function automatic int win_lo(input int pos, input int view, input int size);
		if (pos < view / 2) return 0;
		if (pos + view / 2 > size - 1) return (size > view) ? size - view : 0;
		return pos - view / 2;
	endfunction

	// Present one request and hold it until the block takes it. Valid is left
	// high on return: the caller drives it again in this same time step.
	task automatic issue(input tile_req_t r);
		while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= r.kind;
		cell_x     <= r.cx;
		cell_y     <= r.cy;
		cell_value <= r.val;
		self_id    <= r.sid;
		p1_x       <= r.p1x;
		p1_y       <= r.p1y;
		p2_x       <= r.p2x;
		p2_y       <= r.p2y;
		do @(posedge clk); while (in_stall);
		sent_items++;
	endtask

	task automatic write_tile(input logic [4:0] x, input logic [4:0] y, input logic [7:0] v);
		tile_req_t r;
		r      = noise_req();
		r.kind = REQ_WRITE;
		r.cx   = x;
		r.cy   = y;
		r.val  = v;
		issue(r);
		tile_written[int'(y) * MAP_COLS + int'(x)] = 1'b1;
	endtask

	task automatic clear_shadow();
		tile_req_t r;
		r      = noise_req();
		r.kind = REQ_CLEAR;
		issue(r);
	endtask

	// Fill any unwritten cell of the window first, then send the render.
	task automatic render(input logic [1:0] sid, input logic [4:0] ax, input logic [4:0] ay,
			input logic [4:0] bx, input logic [4:0] by);
		tile_req_t r;
		int        ux, uy, sx, sy, x, y;
		ux = (sid == SELF_P2) ? bx : ax;
		uy = (sid == SELF_P2) ? by : ay;
		sx = win_lo(ux, VIEW_COLS, MAP_COLS);
		sy = win_lo(uy, VIEW_ROWS, MAP_ROWS);
		for (y = sy; y < sy + VIEW_ROWS && y < MAP_ROWS; y++) begin
			for (x = sx; x < sx + VIEW_COLS && x < MAP_COLS; x++) begin
				if (!tile_written[y * MAP_COLS + x]) begin
					write_tile(5'(x), 5'(y), tile_code());
				end
			end
		end
		r      = noise_req();
		r.kind = REQ_RENDER;
		r.sid  = sid;
		r.p1x  = ax;
		r.p1y  = ay;
		r.p2x  = bx;
		r.p2y  = by;
		issue(r);
		cur_x = ux;
		cur_y = uy;
	endtask

	// Drop valid and wait until every predicted write has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Change the empty code only with the block idle, then set the idling mix
	// for the phase that follows.
	task automatic start_phase(input logic [7:0] code, input int tx, input int rx);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= code;
		empty_now = code;
		@(posedge clk);
		cfg_we <= 1'b0;
		tx_pct = tx;
		rx_pct <= rx;
	endtask

	// Mostly renders around the current view with tile writes close by, so
	// the shadow keeps differing in a few cells; the rest are clears, ignored
	// codes, jumps across the map and the odd full drain.
	task automatic random_phase(input int count);
		tile_req_t  r;
		int         goal, k;
		logic [1:0] sid;
		logic [4:0] sx5, sy5, ox5, oy5;
		goal = sent_items + count;
		while (sent_items < goal) begin
			k = $urandom_range(99);
			if (k < 38) begin
				if ($urandom_range(3) != 0) begin
					write_tile(near(cur_x, 9, MAP_COLS), near(cur_y, 1, MAP_ROWS), tile_code());
				end else begin
					write_tile(5'($urandom), 5'($urandom), tile_code());
				end
			end else if (k < 78) begin
				if ($urandom_range(9) == 0) begin
					sid = $urandom_range(1) ? 2'd0 : 2'd3;
				end else begin
					sid = 2'(1 + $urandom_range(1));
				end
				case ($urandom_range(5)) inside
					0, 1: begin
						sx5 = near(cur_x, 3, MAP_COLS);
						sy5 = near(cur_y, 1, MAP_ROWS);
					end
					2: begin
						sx5 = cur_x[4:0];
						sy5 = cur_y[4:0];
					end
					3: begin
						sx5 = $urandom_range(1) ? 5'd31 : 5'd0;
						sy5 = $urandom_range(1) ? 5'd31 : 5'd0;
					end
					default: begin
						sx5 = 5'($urandom);
						sy5 = 5'($urandom);
					end
				endcase
				k = $urandom_range(9);
				if (k < 5) begin
					ox5 = near(sx5, 9, MAP_COLS);
					oy5 = near(sy5, 1, MAP_ROWS);
				end else if (k < 7) begin
					ox5 = sx5;
					oy5 = sy5;
				end else begin
					ox5 = 5'($urandom);
					oy5 = 5'($urandom);
				end
				if (sid == SELF_P2) begin
					render(sid, ox5, oy5, sx5, sy5);
				end else begin
					render(sid, sx5, sy5, ox5, oy5);
				end
			end else if (k < 88) begin
				clear_shadow();
			end else if (k < 96) begin
				r      = noise_req();
				r.kind = REQ_UNUSED;
				issue(r);
			end else begin
				drain_results();
			end
		end
	endtask

	initial begin
		tile_req_t r;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		start_phase(8'h00, 7, 47);

		// Directed: ignored code with every field at both extremes.
		r      = noise_req();
		r.kind = REQ_UNUSED;
		r.cx   = '1; r.cy = '1; r.val = '1; r.sid = '1;
		r.p1x  = '1; r.p1y = '1; r.p2x = '1; r.p2y = '1;
		issue(r);
		r     = '{REQ_UNUSED, 5'd0, 5'd0, 8'h00, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0};
		issue(r);
		write_tile(5'd31, 5'd31, 8'hff);
		write_tile(5'd0, 5'd0, 8'h00);
		// top-left clamp, the other player off the window
		render(2'd1, 5'd0, 5'd0, 5'd31, 5'd31);
		// unchanged map: only the glyph cell is redrawn
		render(2'd1, 5'd0, 5'd0, 5'd31, 5'd31);
		clear_shadow();
		// bottom-right clamp, following player two
		render(SELF_P2, 5'd0, 5'd0, 5'd31, 5'd31);
		// self id 0 follows player one; both players share a cell
		render(2'd0, 5'd31, 5'd0, 5'd31, 5'd0);
		// self id 3 follows player one; the other player is beside him
		render(2'd3, 5'd0, 5'd31, 5'd1, 5'd31);
		// window in the middle: empty code, glyph code and blank code in it
		write_tile(5'd15, 5'd16, empty_now);
		write_tile(5'd16, 5'd16, CHAR_PLAYER);
		write_tile(5'd17, 5'd15, SHADOW_BLANK);
		render(2'd1, 5'd15, 5'd16, 5'd7, 5'd16);
		render(2'd1, 5'd15, 5'd16, 5'd23, 5'd16);
		render(2'd1, 5'd15, 5'd16, 5'd22, 5'd15);
		clear_shadow();
		render(SELF_P2, 5'd8, 5'd16, 5'd15, 5'd16);

		// Random phases: sender idles lightly, then the receiver, then neither.
		start_phase(8'hff, 7, 47);
		random_phase(26);
		start_phase(8'($urandom_range(255)), 47, 7);
		random_phase(26);
		start_phase(CHAR_PLAYER, 0, 0);
		random_phase(26);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
